FILE: hdl/vfte_pkg.sv
// Package: payload types, command and face codes, face corner table.
package vfte_pkg;

	localparam int COORD_W  = 5;
	localparam int FACE_W   = 3;
	localparam int CORNER_W = 3;

	localparam logic CMD_MARK = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd0;
	localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
	localparam logic [FACE_W-1:0] FACE_TOP    = 3'd2;
	localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
	localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd4;
	localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

	typedef struct packed {
		logic               command;
		logic [COORD_W-1:0] vox_x;
		logic [COORD_W-1:0] vox_y;
		logic [COORD_W-1:0] vox_z;
	} req_t;

	typedef struct packed {
		logic [COORD_W-1:0]  out_x;
		logic [COORD_W-1:0]  out_y;
		logic [COORD_W-1:0]  out_z;
		logic [FACE_W-1:0]   face;
		logic                half;
		logic [CORNER_W-1:0] corner_a;
		logic [CORNER_W-1:0] corner_b;
		logic [CORNER_W-1:0] corner_c;
		logic                last;
	} tri_t;

	typedef struct packed {
		logic [CORNER_W-1:0] a;
		logic [CORNER_W-1:0] b;
		logic [CORNER_W-1:0] c;
	} corners_t;

	// indexed by {face, half}
	localparam corners_t CORNER_TABLE [12] = '{
		'{3'd1, 3'd3, 3'd7}, '{3'd1, 3'd7, 3'd5},
		'{3'd2, 3'd3, 3'd7}, '{3'd2, 3'd7, 3'd6},
		'{3'd4, 3'd5, 3'd7}, '{3'd4, 3'd7, 3'd6},
		'{3'd0, 3'd2, 3'd6}, '{3'd0, 3'd6, 3'd4},
		'{3'd0, 3'd1, 3'd5}, '{3'd0, 3'd5, 3'd4},
		'{3'd0, 3'd1, 3'd2}, '{3'd1, 3'd2, 3'd3}
	};

endpackage

FILE: hdl/vfte_if.sv
// Interfaces: request and triangle channels with valid/ready handshake.
interface vfte_req_if;
	logic          valid;
	logic          ready;
	vfte_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vfte_tri_if;
	logic          valid;
	logic          ready;
	vfte_pkg::tri_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/voxel_face_triangle_emitter.sv
// Top level: voxel occupancy map and face triangle sequencer.
//
//  channel   | dir | payload                                   | notes
//  ----------+-----+-------------------------------------------+------------------------
//  request   | in  | command, vox_x, vox_y, vox_z              | mark or emit one voxel
//  triangle  | out | out_x/y/z, face, half, corner_a/b/c, last | 6 to 12 items per emit
//
// A mark writes the map bit at the accepting edge.
// An emit does one neighbour read of the map per axis on its single read port, in the
// lookup state, then emits its triangles, one per cycle while the sink keeps up.
// After reset a clearing pass writes one map entry per cycle over all 2^(3*AXIS_BITS)
// entries (32768 at the default), during which request.ready stays low.
// A stalled sink holds the output register; the sequencer waits on it. The block takes
// the next request once the final triangle of an emit sits in the output register.
module voxel_face_triangle_emitter #(
	parameter int AXIS_BITS = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	vfte_req_if.sink        request,
	vfte_tri_if.source      triangle
);

	localparam int ADDR_W = 3 * AXIS_BITS;
	localparam int DEPTH  = 2 ** ADDR_W;
	localparam int PAD_W  = vfte_pkg::COORD_W + AXIS_BITS;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0] state_q;

	// occupancy map, one bit per voxel
	logic mem [DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_wdata;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_q;

	logic [ADDR_W-1:0] clr_q;

	// wrapped input coordinates
	logic [PAD_W-1:0]     x_pad, y_pad, z_pad;
	logic [AXIS_BITS-1:0] x_in, y_in, z_in;

	logic [AXIS_BITS-1:0] x_q, y_q, z_q;
	logic [1:0]           ax_q;

	// neighbour read in flight
	logic       pend_s1;
	logic [1:0] ax_s1;
	logic       zero_s1;
	logic [2:0] need_q;   // optional face wanted: [0] left, [1] front, [2] bottom

	logic                 accept;
	logic [AXIS_BITS-1:0] sel;
	logic [AXIS_BITS-1:0] dec;
	logic [AXIS_BITS-1:0] nx, ny, nz;

	logic [vfte_pkg::FACE_W-1:0] face_q;
	logic                        half_q;
	logic [vfte_pkg::FACE_W-1:0] next_face;
	logic                        found;
	logic                        is_last;
	logic                        load;
	vfte_pkg::corners_t          crn;

	logic           out_valid_q;
	vfte_pkg::tri_t out_q;

	assign request.ready  = (state_q == ST_IDLE);
	assign accept         = request.valid && request.ready;
	assign triangle.valid = out_valid_q;
	assign triangle.data  = out_q;

	assign x_pad = PAD_W'(request.data.vox_x);
	assign y_pad = PAD_W'(request.data.vox_y);
	assign z_pad = PAD_W'(request.data.vox_z);
	assign x_in  = x_pad[AXIS_BITS-1:0];
	assign y_in  = y_pad[AXIS_BITS-1:0];
	assign z_in  = z_pad[AXIS_BITS-1:0];

	// map write: clearing pass, or mark at the accepting edge
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 1'b0;
		end else begin
			mem_we    = accept && (request.data.command == vfte_pkg::CMD_MARK);
			mem_waddr = {z_in, y_in, x_in};
			mem_wdata = 1'b1;
		end
	end

	// shared decrement: neighbour at minus one on the axis under lookup
	always_comb begin
		case (ax_q)
			2'd0:    sel = x_q;
			2'd1:    sel = y_q;
			default: sel = z_q;
		endcase
		dec = sel - AXIS_BITS'(1);
		nx  = (ax_q == 2'd0) ? dec : x_q;
		ny  = (ax_q == 2'd1) ? dec : y_q;
		nz  = (ax_q == 2'd2) ? dec : z_q;
	end

	assign rd_addr = {nz, ny, nx};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// next face after face_q: fixed faces always, optional ones when wanted
	always_comb begin
		next_face = face_q;
		found     = 1'b0;
		for (int j = 5; j >= 0; j--) begin
			if ((vfte_pkg::FACE_W'(j) > face_q)
			    && ((j < 3) || need_q[2'(j - 3)])) begin
				next_face = vfte_pkg::FACE_W'(j);
				found     = 1'b1;
			end
		end
		is_last = half_q && !found;
		crn     = vfte_pkg::CORNER_TABLE[{face_q, half_q}];
	end

	assign load = (state_q == ST_EMIT) && (!out_valid_q || triangle.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ax_q        <= '0;
			pend_s1     <= 1'b0;
			need_q      <= '0;
			face_q      <= vfte_pkg::FACE_RIGHT;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_LOOKUP);
			// read data lands in rd_q in the cycle after the address; done before the flags are used
			if (pend_s1) begin
				need_q[ax_s1] <= zero_s1 || !rd_q;
			end

			// output register: filled on load, emptied when the sink takes it
			out_valid_q <= load || (out_valid_q && !triangle.ready);

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == {ADDR_W{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (request.data.command == vfte_pkg::CMD_EMIT)) begin
						state_q <= ST_LOOKUP;
						ax_q    <= '0;
					end
				end
				ST_LOOKUP: begin
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= ST_EMIT;
						face_q  <= vfte_pkg::FACE_RIGHT;
						half_q  <= 1'b0;
					end else begin
						ax_q <= ax_q + 2'd1;
					end
				end
				ST_EMIT: begin
					if (load) begin
						half_q <= !half_q;
						if (half_q) begin
							face_q <= next_face;
						end
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= z_in;
		end
		ax_s1   <= ax_q;
		zero_s1 <= (sel == '0);
		if (load) begin
			out_q.out_x    <= vfte_pkg::COORD_W'(x_q);
			out_q.out_y    <= vfte_pkg::COORD_W'(y_q);
			out_q.out_z    <= vfte_pkg::COORD_W'(z_q);
			out_q.face     <= face_q;
			out_q.half     <= half_q;
			out_q.corner_a <= crn.a;
			out_q.corner_b <= crn.b;
			out_q.corner_c <= crn.c;
			out_q.last     <= is_last;
		end
	end

endmodule
